// ----- hdl/tcch_pkg.sv -----
// Shared constants, types and tables for the tilt-compensated compass heading pipeline.
// No dependencies; every other file of the block refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package tcch_pkg;

	localparam int SAMPLE_BITS  = 16;
	localparam int FACING_BITS  = 16;
	localparam int UNIT_BITS    = 30;

	// normalizer widths
	localparam int MAG_W        = UNIT_BITS;
	localparam int SQ_W         = 2 * MAG_W;
	localparam int SUM_W        = SQ_W + 2;
	localparam int ROOT_W       = SUM_W / 2;
	localparam int REM_W        = ROOT_W + 2;
	localparam int QUO_W        = UNIT_BITS + 1;
	localparam int UNIT_W       = UNIT_BITS + 2;

	// cross products
	localparam int EP_W         = 2 * SAMPLE_BITS;
	localparam int E_W          = EP_W + 1;
	localparam int NP_W         = SAMPLE_BITS + UNIT_W;
	localparam int N_W          = NP_W + 1;

	// dot products and arctangent
	localparam int DP_W         = UNIT_W + FACING_BITS;
	localparam int DOT_W        = DP_W + 2;
	localparam int CX_W         = DOT_W + 2;
	localparam int CORDIC_STEPS = 20;
	localparam int ANGLE_FRAC   = 16;
	localparam int Z_W          = 26;
	localparam int DEG_W        = 10;
	localparam int WRAP_W       = DEG_W + 1;
	localparam int HEAD_W       = 9;
	localparam int SHIFT_W      = 6;

	localparam logic signed [Z_W-1:0]    ANGLE_90   = Z_W'(90 * (1 << ANGLE_FRAC));
	localparam logic [Z_W-1:0]           ROUND_HALF = Z_W'(1 << (ANGLE_FRAC - 1));
	localparam logic signed [WRAP_W-1:0] DEG_FULL   = WRAP_W'(360);

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = FACING_BITS;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FACING_X = 2'd0,
		CFG_FACING_Y = 2'd1,
		CFG_FACING_Z = 2'd2
	} cfg_reg_t;

	// data that rides along a normalizer
	typedef struct packed {
		logic [2:0][SAMPLE_BITS-1:0] acc;
		logic [2:0][UNIT_W-1:0]      east;
		logic                        degen;
	} tcch_side_t;

	// atan(2^-i) in degrees, Q16, rounded to nearest
	function automatic logic signed [Z_W-1:0] atan_q16(logic [4:0] i);
		logic signed [Z_W-1:0] a;
		case (i)
			5'd0:    a = Z_W'(2949120);
			5'd1:    a = Z_W'(1740967);
			5'd2:    a = Z_W'(919879);
			5'd3:    a = Z_W'(466945);
			5'd4:    a = Z_W'(234379);
			5'd5:    a = Z_W'(117304);
			5'd6:    a = Z_W'(58666);
			5'd7:    a = Z_W'(29335);
			5'd8:    a = Z_W'(14668);
			5'd9:    a = Z_W'(7334);
			5'd10:   a = Z_W'(3667);
			5'd11:   a = Z_W'(1833);
			5'd12:   a = Z_W'(917);
			5'd13:   a = Z_W'(458);
			5'd14:   a = Z_W'(229);
			5'd15:   a = Z_W'(115);
			5'd16:   a = Z_W'(57);
			5'd17:   a = Z_W'(29);
			5'd18:   a = Z_W'(14);
			5'd19:   a = Z_W'(7);
			5'd20:   a = Z_W'(4);
			5'd21:   a = Z_W'(2);
			5'd22:   a = Z_W'(1);
			default: a = '0;
		endcase
		return a;
	endfunction

	// smallest right shift that brings every set bit below 2^UNIT_BITS
	function automatic logic [SHIFT_W-1:0] norm_shift(logic [63:0] orv);
		logic [SHIFT_W-1:0] k;
		k = '0;
		for (int b = UNIT_BITS; b < 64; b++) begin
			if (orv[b]) begin
				k = SHIFT_W'(b - UNIT_BITS + 1);
			end
		end
		return k;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/tcch_ifs.sv -----
// Channel interfaces of the compass heading block: sample input, heading output, config writes.
// Depends on tcch_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tcch_in_if;
	logic valid;
	logic ready;
	logic signed [tcch_pkg::SAMPLE_BITS-1:0] accel_x;
	logic signed [tcch_pkg::SAMPLE_BITS-1:0] accel_y;
	logic signed [tcch_pkg::SAMPLE_BITS-1:0] accel_z;
	logic signed [tcch_pkg::SAMPLE_BITS-1:0] mag_x;
	logic signed [tcch_pkg::SAMPLE_BITS-1:0] mag_y;
	logic signed [tcch_pkg::SAMPLE_BITS-1:0] mag_z;

	modport source (output valid, accel_x, accel_y, accel_z, mag_x, mag_y, mag_z, input ready);
	modport sink (input valid, accel_x, accel_y, accel_z, mag_x, mag_y, mag_z, output ready);
endinterface

interface tcch_out_if;
	logic valid;
	logic ready;
	logic [tcch_pkg::HEAD_W-1:0] heading_deg;
	logic degenerate;

	modport source (output valid, heading_deg, degenerate, input ready);
	modport sink (input valid, heading_deg, degenerate, output ready);
endinterface

interface tcch_cfg_if;
	logic valid;
	logic ready;
	logic [tcch_pkg::CFG_IDX_W-1:0] index;
	logic [tcch_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/tcch_norm.sv -----
// Pipelined vector normalizer: squares, sum, bit-serial square root, restoring divide to Q30.
// Depends on tcch_pkg. One vector per cycle, held by en.
`timescale 1ns / 1ps
`default_nettype none

module tcch_norm (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  logic [tcch_pkg::MAG_W-1:0]           in_mag [3],
	input  logic [2:0]                           in_neg,
	input  tcch_pkg::tcch_side_t                 in_side,
	output logic                                 out_valid,
	output logic signed [tcch_pkg::UNIT_W-1:0]   out_unit [3],
	output tcch_pkg::tcch_side_t                 out_side
);

	localparam int MW  = tcch_pkg::MAG_W;
	localparam int SW  = tcch_pkg::SUM_W;
	localparam int RW  = tcch_pkg::ROOT_W;
	localparam int XW  = tcch_pkg::REM_W;
	localparam int QW  = tcch_pkg::QUO_W;
	localparam int UW  = tcch_pkg::UNIT_W;
	localparam int SQW = tcch_pkg::SQ_W;

	// squares
	logic                 v_s1;
	logic [MW-1:0]        mag_s1 [3];
	logic [SQW-1:0]       sq_s1 [3];
	logic [2:0]           neg_s1;
	tcch_pkg::tcch_side_t side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				mag_s1[c] <= in_mag[c];
				sq_s1[c]  <= SQW'(in_mag[c]) * SQW'(in_mag[c]);
			end
			neg_s1  <= in_neg;
			side_s1 <= in_side;
		end
	end

	// square root, one result bit per stage; stage 0 holds the sum
	logic                 rt_v_s    [0:RW];
	logic [SW-1:0]        rt_rad_s  [0:RW];
	logic [XW-1:0]        rt_rem_s  [0:RW];
	logic [RW-1:0]        rt_root_s [0:RW];
	logic [MW-1:0]        rt_mag_s  [0:RW][3];
	logic [2:0]           rt_neg_s  [0:RW];
	tcch_pkg::tcch_side_t rt_side_s [0:RW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_v_s[0] <= 1'b0;
		end else if (en) begin
			rt_v_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_rad_s[0]  <= SW'(sq_s1[0]) + SW'(sq_s1[1]) + SW'(sq_s1[2]);
			rt_rem_s[0]  <= '0;
			rt_root_s[0] <= '0;
			rt_mag_s[0]  <= mag_s1;
			rt_neg_s[0]  <= neg_s1;
			rt_side_s[0] <= side_s1;
		end
	end

	for (genvar j = 0; j < RW; j++) begin : g_sqrt
		logic [XW+1:0] cur;
		logic [XW+1:0] trial;
		logic          fit;

		always_comb begin
			cur   = {rt_rem_s[j], rt_rad_s[j][SW-1 -: 2]};
			trial = (XW+2)'({rt_root_s[j], 2'b01});
			fit   = (cur >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_s[j+1] <= 1'b0;
			end else if (en) begin
				rt_v_s[j+1] <= rt_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_rem_s[j+1]  <= fit ? XW'(cur - trial) : XW'(cur);
				rt_root_s[j+1] <= {rt_root_s[j][RW-2:0], fit};
				rt_rad_s[j+1]  <= {rt_rad_s[j][SW-3:0], 2'b00};
				rt_mag_s[j+1]  <= rt_mag_s[j];
				rt_neg_s[j+1]  <= rt_neg_s[j];
				rt_side_s[j+1] <= rt_side_s[j];
			end
		end
	end

	// divide (mag << 30) / len, one quotient bit per stage; stage 0 loads mag >> 1
	logic                 dv_v_s    [0:QW];
	logic [RW-1:0]        dv_rem_s  [0:QW][3];
	logic [QW-1:0]        dv_quo_s  [0:QW][3];
	logic [RW-1:0]        dv_len_s  [0:QW];
	logic [2:0]           dv_neg_s  [0:QW];
	tcch_pkg::tcch_side_t dv_side_s [0:QW];
	logic [2:0]           dv_lsb_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (en) begin
			dv_v_s[0] <= rt_v_s[RW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				dv_rem_s[0][c] <= RW'(rt_mag_s[RW][c] >> 1);
				dv_quo_s[0][c] <= '0;
				dv_lsb_s[c]    <= rt_mag_s[RW][c][0];
			end
			dv_len_s[0]  <= rt_root_s[RW];
			dv_neg_s[0]  <= rt_neg_s[RW];
			dv_side_s[0] <= rt_side_s[RW];
		end
	end

	for (genvar t = 0; t < QW; t++) begin : g_div
		logic [RW:0] sh [3];
		logic [2:0]  ge;
		logic [2:0]  bin;

		always_comb begin
			if (t == 0) begin
				bin = dv_lsb_s;
			end else begin
				bin = '0;
			end
			for (int c = 0; c < 3; c++) begin
				sh[c] = {dv_rem_s[t][c], bin[c]};
				ge[c] = (sh[c] >= (RW+1)'(dv_len_s[t]));
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[t+1] <= 1'b0;
			end else if (en) begin
				dv_v_s[t+1] <= dv_v_s[t];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int c = 0; c < 3; c++) begin
					dv_rem_s[t+1][c] <= ge[c] ? RW'(sh[c] - (RW+1)'(dv_len_s[t])) : RW'(sh[c]);
					dv_quo_s[t+1][c] <= {dv_quo_s[t][c][QW-2:0], ge[c]};
				end
				dv_len_s[t+1]  <= dv_len_s[t];
				dv_neg_s[t+1]  <= dv_neg_s[t];
				dv_side_s[t+1] <= dv_side_s[t];
			end
		end
	end

	// apply signs
	logic signed [UW-1:0] qs [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			qs[c] = signed'(UW'(dv_quo_s[QW][c]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv_v_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				out_unit[c] <= dv_neg_s[QW][c] ? -qs[c] : qs[c];
			end
			out_side <= dv_side_s[QW];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/tilt_compensated_compass_heading.sv -----
// Top level of the tilt-compensated compass heading pipeline.
// Depends on tcch_pkg, the channel interfaces in tcch_ifs and the normalizer tcch_norm.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Word                                       Handshake
// sample    in   accel_x/y/z, mag_x/y/z (signed 16 bit)     valid/ready
// heading   out  heading_deg (9 bit), degenerate (1 bit)    valid/ready
// cfg       in   index (2 bit), data (16 bit facing comp.)  valid/ready, ready always high
//
// One sample word enters per cycle while heading does not stall the pipeline.
// Depth is set by the two normalizers (bit-serial square root and divide, 66 stages
// each) and the 20-stage arctangent CORDIC.
// Reset clears all stage valid bits and loads the facing vector (1, 0, 0).
// The whole pipeline advances whenever the output register is empty or being taken;
// a stall on heading freezes every stage, and sample.ready follows it.

module tilt_compensated_compass_heading (
	input  logic       clk,
	input  logic       arst_n,
	tcch_in_if.sink    sample,
	tcch_out_if.source heading,
	tcch_cfg_if.sink   cfg
);

	localparam int SB   = tcch_pkg::SAMPLE_BITS;
	localparam int FB   = tcch_pkg::FACING_BITS;
	localparam int MW   = tcch_pkg::MAG_W;
	localparam int UW   = tcch_pkg::UNIT_W;
	localparam int EPW  = tcch_pkg::EP_W;
	localparam int EW   = tcch_pkg::E_W;
	localparam int NPW  = tcch_pkg::NP_W;
	localparam int NW   = tcch_pkg::N_W;
	localparam int DPW  = tcch_pkg::DP_W;
	localparam int DW   = tcch_pkg::DOT_W;
	localparam int CW   = tcch_pkg::CX_W;
	localparam int ZW   = tcch_pkg::Z_W;
	localparam int STEPS = tcch_pkg::CORDIC_STEPS;

	logic en;
	logic out_v_q;

	// advance everything when the output slot is free or being drained
	assign en           = !out_v_q || heading.ready;
	assign sample.ready = en;
	assign cfg.ready    = 1'b1;

	// facing vector registers
	logic signed [FB-1:0] facing_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			facing_q[0] <= FB'(1);
			facing_q[1] <= '0;
			facing_q[2] <= '0;
		end else if (cfg.valid) begin
			case (tcch_pkg::cfg_reg_t'(cfg.index))
				tcch_pkg::CFG_FACING_X: facing_q[0] <= signed'(cfg.data);
				tcch_pkg::CFG_FACING_Y: facing_q[1] <= signed'(cfg.data);
				tcch_pkg::CFG_FACING_Z: facing_q[2] <= signed'(cfg.data);
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// s1: partial products of east = mag x accel
	// ---------------------------------------------------------------
	logic                  v_s1;
	logic signed [EPW-1:0] epr_s1 [6];
	logic [2:0][SB-1:0]    acc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			epr_s1[0] <= EPW'(sample.mag_y) * EPW'(sample.accel_z);
			epr_s1[1] <= EPW'(sample.mag_z) * EPW'(sample.accel_y);
			epr_s1[2] <= EPW'(sample.mag_z) * EPW'(sample.accel_x);
			epr_s1[3] <= EPW'(sample.mag_x) * EPW'(sample.accel_z);
			epr_s1[4] <= EPW'(sample.mag_x) * EPW'(sample.accel_y);
			epr_s1[5] <= EPW'(sample.mag_y) * EPW'(sample.accel_x);
			acc_s1    <= {sample.accel_z, sample.accel_y, sample.accel_x};
		end
	end

	// s2: east components, exact
	logic                 v_s2;
	logic signed [EW-1:0] e_raw_s2 [3];
	logic [2:0][SB-1:0]   acc_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				e_raw_s2[c] <= EW'(epr_s1[2*c]) - EW'(epr_s1[2*c+1]);
			end
			acc_s2 <= acc_s1;
		end
	end

	// s3: magnitudes and signs; flag a zero east vector
	logic               v_s3;
	logic [EW-1:0]      emag_s3 [3];
	logic [2:0]         eneg_s3;
	logic               edeg_s3;
	logic [2:0][SB-1:0] acc_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				emag_s3[c] <= e_raw_s2[c][EW-1] ? EW'(-e_raw_s2[c]) : EW'(e_raw_s2[c]);
				eneg_s3[c] <= e_raw_s2[c][EW-1];
			end
			edeg_s3 <= (e_raw_s2[0] == '0) && (e_raw_s2[1] == '0) && (e_raw_s2[2] == '0);
			acc_s3  <= acc_s2;
		end
	end

	// s4: common right shift so every magnitude fits the normalizer
	logic [tcch_pkg::SHIFT_W-1:0] e_k;
	logic [MW-1:0]                e_shift [3];

	always_comb begin
		e_k = tcch_pkg::norm_shift(64'(emag_s3[0] | emag_s3[1] | emag_s3[2]));
		for (int c = 0; c < 3; c++) begin
			e_shift[c] = MW'(emag_s3[c] >> e_k);
		end
	end

	logic                 v_s4;
	logic [MW-1:0]        emag_s4 [3];
	logic [2:0]           eneg_s4;
	tcch_pkg::tcch_side_t side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			emag_s4       <= e_shift;
			eneg_s4       <= eneg_s3;
			side_s4.acc   <= acc_s3;
			side_s4.east  <= '0;
			side_s4.degen <= edeg_s3;
		end
	end

	// ---------------------------------------------------------------
	// unit east
	// ---------------------------------------------------------------
	logic                 n1_valid;
	logic signed [UW-1:0] n1_unit [3];
	tcch_pkg::tcch_side_t n1_side;

	tcch_norm u_norm_east (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.in_mag    (emag_s4),
		.in_neg    (eneg_s4),
		.in_side   (side_s4),
		.out_valid (n1_valid),
		.out_unit  (n1_unit),
		.out_side  (n1_side)
	);

	// s5: partial products of north = accel x e
	logic                  v_s5;
	logic signed [NPW-1:0] npr_s5 [6];
	tcch_pkg::tcch_side_t  side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= n1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			npr_s5[0] <= NPW'($signed(n1_side.acc[1])) * NPW'(n1_unit[2]);
			npr_s5[1] <= NPW'($signed(n1_side.acc[2])) * NPW'(n1_unit[1]);
			npr_s5[2] <= NPW'($signed(n1_side.acc[2])) * NPW'(n1_unit[0]);
			npr_s5[3] <= NPW'($signed(n1_side.acc[0])) * NPW'(n1_unit[2]);
			npr_s5[4] <= NPW'($signed(n1_side.acc[0])) * NPW'(n1_unit[1]);
			npr_s5[5] <= NPW'($signed(n1_side.acc[1])) * NPW'(n1_unit[0]);
			side_s5.acc   <= n1_side.acc;
			side_s5.east  <= {n1_unit[2], n1_unit[1], n1_unit[0]};
			side_s5.degen <= n1_side.degen;
		end
	end

	// s6: north components, exact in units of 2^-30
	logic                 v_s6;
	logic signed [NW-1:0] n_raw_s6 [3];
	tcch_pkg::tcch_side_t side_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				n_raw_s6[c] <= NW'(npr_s5[2*c]) - NW'(npr_s5[2*c+1]);
			end
			side_s6 <= side_s5;
		end
	end

	// s7: magnitudes and signs; a zero north vector also marks the word degenerate
	logic                 v_s7;
	logic [NW-1:0]        nmag_s7 [3];
	logic [2:0]           nneg_s7;
	tcch_pkg::tcch_side_t side_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				nmag_s7[c] <= n_raw_s6[c][NW-1] ? NW'(-n_raw_s6[c]) : NW'(n_raw_s6[c]);
				nneg_s7[c] <= n_raw_s6[c][NW-1];
			end
			side_s7.acc   <= side_s6.acc;
			side_s7.east  <= side_s6.east;
			side_s7.degen <= side_s6.degen ||
				((n_raw_s6[0] == '0) && (n_raw_s6[1] == '0) && (n_raw_s6[2] == '0));
		end
	end

	// s8: common right shift
	logic [tcch_pkg::SHIFT_W-1:0] n_k;
	logic [MW-1:0]                n_shift [3];

	always_comb begin
		n_k = tcch_pkg::norm_shift(64'(nmag_s7[0] | nmag_s7[1] | nmag_s7[2]));
		for (int c = 0; c < 3; c++) begin
			n_shift[c] = MW'(nmag_s7[c] >> n_k);
		end
	end

	logic                 v_s8;
	logic [MW-1:0]        nmag_s8 [3];
	logic [2:0]           nneg_s8;
	tcch_pkg::tcch_side_t side_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nmag_s8 <= n_shift;
			nneg_s8 <= nneg_s7;
			side_s8 <= side_s7;
		end
	end

	// ---------------------------------------------------------------
	// unit north
	// ---------------------------------------------------------------
	logic                 n2_valid;
	logic signed [UW-1:0] n2_unit [3];
	tcch_pkg::tcch_side_t n2_side;

	tcch_norm u_norm_north (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s8),
		.in_mag    (nmag_s8),
		.in_neg    (nneg_s8),
		.in_side   (side_s8),
		.out_valid (n2_valid),
		.out_unit  (n2_unit),
		.out_side  (n2_side)
	);

	// s9: dot product terms, x from north and y from east
	logic                  v_s9;
	logic signed [DPW-1:0] dpx_s9 [3];
	logic signed [DPW-1:0] dpy_s9 [3];
	logic                  deg_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= n2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				dpx_s9[c] <= DPW'(n2_unit[c]) * DPW'(facing_q[c]);
				dpy_s9[c] <= DPW'($signed(n2_side.east[c])) * DPW'(facing_q[c]);
			end
			deg_s9 <= n2_side.degen;
		end
	end

	// s10: sum the terms
	logic                 v_s10;
	logic signed [DW-1:0] x_s10;
	logic signed [DW-1:0] y_s10;
	logic                 deg_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s10   <= DW'(dpx_s9[0]) + DW'(dpx_s9[1]) + DW'(dpx_s9[2]);
			y_s10   <= DW'(dpy_s9[0]) + DW'(dpy_s9[1]) + DW'(dpy_s9[2]);
			deg_s10 <= deg_s9;
		end
	end

	// ---------------------------------------------------------------
	// CORDIC: stage 0 turns a left-half vector by 90 degrees, then one step per stage
	// ---------------------------------------------------------------
	logic                 cv_s    [0:STEPS];
	logic signed [CW-1:0] cx_s    [0:STEPS];
	logic signed [CW-1:0] cy_s    [0:STEPS];
	logic signed [ZW-1:0] cz_s    [0:STEPS];
	logic                 cdeg_s  [0:STEPS];
	logic                 czero_s [0:STEPS];

	logic signed [CW-1:0] pre_x;
	logic signed [CW-1:0] pre_y;
	logic signed [ZW-1:0] pre_z;
	logic signed [CW-1:0] ext_x;
	logic signed [CW-1:0] ext_y;

	always_comb begin
		ext_x = CW'(x_s10);
		ext_y = CW'(y_s10);
		if (ext_x[CW-1]) begin
			if (!ext_y[CW-1]) begin
				pre_x = ext_y;
				pre_y = -ext_x;
				pre_z = tcch_pkg::ANGLE_90;
			end else begin
				pre_x = -ext_y;
				pre_y = ext_x;
				pre_z = -tcch_pkg::ANGLE_90;
			end
		end else begin
			pre_x = ext_x;
			pre_y = ext_y;
			pre_z = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_s[0] <= 1'b0;
		end else if (en) begin
			cv_s[0] <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s[0]    <= pre_x;
			cy_s[0]    <= pre_y;
			cz_s[0]    <= pre_z;
			cdeg_s[0]  <= deg_s10;
			czero_s[0] <= (x_s10 == '0) && (y_s10 == '0);
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_cordic
		logic signed [CW-1:0] xs;
		logic signed [CW-1:0] ys;
		logic signed [ZW-1:0] da;
		logic                 cw;

		always_comb begin
			xs = cx_s[i] >>> i;
			ys = cy_s[i] >>> i;
			da = tcch_pkg::atan_q16(5'(i));
			cw = !cy_s[i][CW-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[i+1] <= 1'b0;
			end else if (en) begin
				cv_s[i+1] <= cv_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (cw) begin
					cx_s[i+1] <= cx_s[i] + ys;
					cy_s[i+1] <= cy_s[i] - xs;
					cz_s[i+1] <= cz_s[i] + da;
				end else begin
					cx_s[i+1] <= cx_s[i] - ys;
					cy_s[i+1] <= cy_s[i] + xs;
					cz_s[i+1] <= cz_s[i] - da;
				end
				cdeg_s[i+1]  <= cdeg_s[i];
				czero_s[i+1] <= czero_s[i];
			end
		end
	end

	// s12: round the Q16 angle to whole degrees, ties away from zero
	logic [ZW-1:0]                    z_abs;
	logic [tcch_pkg::DEG_W-1:0]       z_rnd;

	always_comb begin
		z_abs = cz_s[STEPS][ZW-1] ? ZW'(-cz_s[STEPS]) : ZW'(cz_s[STEPS]);
		z_rnd = tcch_pkg::DEG_W'((z_abs + tcch_pkg::ROUND_HALF) >> tcch_pkg::ANGLE_FRAC);
	end

	logic                              v_s12;
	logic signed [tcch_pkg::DEG_W-1:0] deg_s12;
	logic                              degen_s12;
	logic                              zero_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
		end else if (en) begin
			v_s12 <= cv_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			deg_s12   <= cz_s[STEPS][ZW-1] ? -signed'(z_rnd) : signed'(z_rnd);
			degen_s12 <= cdeg_s[STEPS];
			zero_s12  <= czero_s[STEPS];
		end
	end

	// output register: wrap into 0..359, force 0 for degenerate or zero projections
	logic signed [tcch_pkg::WRAP_W-1:0] wrap_deg;

	always_comb begin
		wrap_deg = tcch_pkg::WRAP_W'(deg_s12);
		if (wrap_deg[tcch_pkg::WRAP_W-1]) begin
			wrap_deg = wrap_deg + tcch_pkg::DEG_FULL;
		end else if (wrap_deg >= tcch_pkg::DEG_FULL) begin
			wrap_deg = wrap_deg - tcch_pkg::DEG_FULL;
		end
	end

	logic [tcch_pkg::HEAD_W-1:0] heading_q;
	logic                        degen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			heading_q <= (degen_s12 || zero_s12) ? '0 : tcch_pkg::HEAD_W'(wrap_deg);
			degen_q   <= degen_s12;
		end
	end

	assign heading.valid       = out_v_q;
	assign heading.heading_deg = heading_q;
	assign heading.degenerate  = degen_q;

endmodule

`default_nettype wire

// ----- dv/tilt_compensated_compass_heading_test.sv -----
// Testbench for the tilt-compensated compass heading block: directed and random sample words,
// facing-vector writes between phases, a fixed-point heading predictor and an in-order scoreboard.
// Depends on tcch_pkg, the channel interfaces in tcch_ifs and the block itself.
`timescale 1ns / 1ps

module tilt_compensated_compass_heading_test;

	localparam int LATENCY     = 165;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		logic signed [15:0] acc [3];
		logic signed [15:0] mag [3];
	} sample_word_t;

	typedef struct {
		logic [8:0] heading_deg;
		logic       degenerate;
	} heading_word_t;

	// Heading predictor state: the facing vector as the block holds it.
	logic signed [15:0] facing [3];

	function automatic longint floor_shr(longint v, int s);
		if (v >= 0) begin
			return v >>> s;
		end
		return -1 - ((-1 - v) >>> s);
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned res, bit_w;
		res = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > v) bit_w >>= 2;
		while (bit_w != 0) begin
			if (v >= res + bit_w) begin
				v -= res + bit_w;
				res = (res >> 1) + bit_w;
			end else begin
				res >>= 1;
			end
			bit_w >>= 2;
		end
		return res;
	endfunction

	// Scale a vector to unit length in Q30; return 0 for the zero vector.
	function automatic bit to_unit(input longint v [3], output longint u [3]);
		longint unsigned mg [3];
		longint unsigned mx, sum, len;
		int k;
		mx = 0;
		sum = 0;
		k = 0;
		for (int i = 0; i < 3; i++) begin
			mg[i] = (v[i] < 0) ? -v[i] : v[i];
			if (mg[i] > mx) mx = mg[i];
		end
		if (mx == 0) return 0;
		while ((mx >> k) >= (64'd1 << 30)) k++;
		for (int i = 0; i < 3; i++) begin
			mg[i] >>= k;
			sum += mg[i] * mg[i];
		end
		len = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			u[i] = longint'((mg[i] << 30) / len);
			if (v[i] < 0) u[i] = -u[i];
		end
		return 1;
	endfunction

	function automatic void cross3(input longint p [3], input longint q [3],
			output longint r [3]);
		r[0] = p[1] * q[2] - p[2] * q[1];
		r[1] = p[2] * q[0] - p[0] * q[2];
		r[2] = p[0] * q[1] - p[1] * q[0];
	endfunction

	// Vectoring arctangent in degrees Q16, same step table as the hardware.
	function automatic longint atan2_q16(longint x, longint y);
		longint z, t, dx, dy;
		longint tbl [23] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
			29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};
		z = 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = 90 * 65536;
			end else begin
				x = -y; y = t; z = -90 * 65536;
			end
		end
		for (int i = 0; i < tcch_pkg::CORDIC_STEPS; i++) begin
			dx = floor_shr(y, i);
			dy = floor_shr(x, i);
			if (y >= 0) begin
				x += dx; y -= dy; z += (i < 23) ? tbl[i] : 0;
			end else begin
				x -= dx; y += dy; z -= (i < 23) ? tbl[i] : 0;
			end
		end
		return z;
	endfunction

	function automatic heading_word_t predict_heading(sample_word_t s);
		heading_word_t r;
		longint a [3], m [3], er [3], e [3], nr [3], n [3];
		longint x, y, z, d;
		r.heading_deg = '0;
		r.degenerate = 1'b0;
		for (int i = 0; i < 3; i++) begin
			a[i] = s.acc[i];
			m[i] = s.mag[i];
		end
		cross3(m, a, er);
		if (!to_unit(er, e)) begin
			r.degenerate = 1'b1;
			return r;
		end
		cross3(a, e, nr);
		if (!to_unit(nr, n)) begin
			r.degenerate = 1'b1;
			return r;
		end
		y = 0;
		x = 0;
		for (int i = 0; i < 3; i++) begin
			y += e[i] * longint'(facing[i]);
			x += n[i] * longint'(facing[i]);
		end
		// Both dot products zero: heading 0, not flagged.
		if (x == 0 && y == 0) return r;
		z = atan2_q16(x, y);
		d = (z >= 0) ? ((z + 32768) >>> 16) : -((-z + 32768) >>> 16);
		if (d < 0) d += 360;
		if (d >= 360) d -= 360;
		r.heading_deg = 9'(d);
		return r;
	endfunction

	class heading_scoreboard;
		heading_word_t pending [$];
		int errors;

		function void note_sample(sample_word_t s);
			pending.push_back(predict_heading(s));
		endfunction

		function void check_heading(heading_word_t got);
			heading_word_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected heading word: heading_deg %0d degenerate %0b",
					$realtime, got.heading_deg, got.degenerate);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.heading_deg !== want.heading_deg) begin
				$display("%0t: heading_deg mismatch: expected %0d actual %0d",
					$realtime, want.heading_deg, got.heading_deg);
				errors++;
			end
			if (got.degenerate !== want.degenerate) begin
				$display("%0t: degenerate mismatch: expected %0b actual %0b",
					$realtime, want.degenerate, got.degenerate);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	tcch_in_if  sample ();
	tcch_out_if heading ();
	tcch_cfg_if cfg ();

	tilt_compensated_compass_heading dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample.sink),
		.heading (heading.source),
		.cfg     (cfg.sink)
	);

	heading_scoreboard sb;
	int idle_cycles;
	int stall_mode;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Sample on the rising edge: note accepted sample words, check heading words.
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample.valid && sample.ready) begin
				sample_word_t s;
				s.acc[0] = sample.accel_x; s.acc[1] = sample.accel_y; s.acc[2] = sample.accel_z;
				s.mag[0] = sample.mag_x;   s.mag[1] = sample.mag_y;   s.mag[2] = sample.mag_z;
				sb.note_sample(s);
			end
			if (heading.valid && heading.ready) begin
				heading_word_t h;
				h.heading_deg = heading.heading_deg;
				h.degenerate = heading.degenerate;
				sb.check_heading(h);
			end
			if ((sample.valid && sample.ready) || (heading.valid && heading.ready) ||
					(cfg.valid && cfg.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tilt_compensated_compass_heading test failed");
				$finish;
			end
		end
	end

	// Receiver backpressure: the pattern changes per phase; mode 0 never stalls.
	always @(negedge clk) begin
		case (stall_mode)
			0: begin
				heading.ready <= 1'b1;
			end
			1: begin
				heading.ready <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				heading.ready <= ($urandom_range(0, 1) != 0) && !heading.ready;
			end
		endcase
	end

	// Present one sample word at the falling edge and hold it until taken.
	task automatic send_sample(sample_word_t s);
		sample.valid <= 1'b1;
		sample.accel_x <= s.acc[0]; sample.accel_y <= s.acc[1]; sample.accel_z <= s.acc[2];
		sample.mag_x <= s.mag[0];   sample.mag_y <= s.mag[1];   sample.mag_z <= s.mag[2];
		do @(posedge clk); while (!sample.ready);
		@(negedge clk);
	endtask

	task automatic drop_valid();
		sample.valid <= 1'b0;
	endtask

	task automatic write_facing(tcch_pkg::cfg_reg_t idx, logic [15:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		facing[idx] = val;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// Wait until every heading word has come back, then let the pipe drain fully.
	task automatic drain();
		drop_valid();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
	endtask

	function automatic logic [15:0] rand_field();
		case ($urandom_range(0, 5))
			0:       return 16'h8000;
			1:       return 16'h7fff;
			2:       return 16'(int'($urandom_range(0, 16)) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic sample_word_t rand_sample();
		sample_word_t s;
		for (int i = 0; i < 3; i++) begin
			s.acc[i] = rand_field();
			s.mag[i] = rand_field();
		end
		// Parallel vectors give a zero east vector now and then.
		if ($urandom_range(0, 19) == 0) begin
			for (int i = 0; i < 3; i++) s.mag[i] = s.acc[i];
		end
		return s;
	endfunction

	function automatic sample_word_t make_sample(int ax, int ay, int az, int mx, int my, int mz);
		sample_word_t s;
		s.acc[0] = 16'(ax); s.acc[1] = 16'(ay); s.acc[2] = 16'(az);
		s.mag[0] = 16'(mx); s.mag[1] = 16'(my); s.mag[2] = 16'(mz);
		return s;
	endfunction

	// Random phase: bursts of back-to-back words separated by random gaps.
	task automatic random_phase(int count);
		int burst;
		while (count > 0) begin
			burst = $urandom_range(1, 40);
			while (burst > 0 && count > 0) begin
				send_sample(rand_sample());
				burst--;
				count--;
			end
			if ($urandom_range(0, 2) != 0) begin
				drop_valid();
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
		end
	endtask

	initial begin
		sample_word_t dir [$];
		sb = new();
		facing[0] = 16'sd1;
		facing[1] = 16'sd0;
		facing[2] = 16'sd0;
		idle_cycles = 0;
		stall_mode = 0;
		arst_n = 1'b0;
		sample.valid = 1'b0;
		sample.accel_x = '0; sample.accel_y = '0; sample.accel_z = '0;
		sample.mag_x = '0;   sample.mag_y = '0;   sample.mag_z = '0;
		heading.ready = 1'b1;
		cfg.valid = 1'b0;
		cfg.index = tcch_pkg::CFG_FACING_X;
		cfg.data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: level device, tilts, extremes, zero and parallel vectors.
		dir.push_back(make_sample(0, 0, 16384, 10000, 0, -5000));
		dir.push_back(make_sample(0, 0, 16384, 0, 10000, -5000));
		dir.push_back(make_sample(0, 0, 16384, -10000, 0, -5000));
		dir.push_back(make_sample(0, 0, 16384, 0, -10000, -5000));
		dir.push_back(make_sample(0, 0, 16384, 7071, -7071, 0));
		dir.push_back(make_sample(3000, -2000, 15000, 8000, 3000, -9000));
		dir.push_back(make_sample(0, 0, 0, 0, 0, 0));
		dir.push_back(make_sample(0, 0, 0, 1234, -77, 32767));
		dir.push_back(make_sample(100, 200, 300, 100, 200, 300));
		dir.push_back(make_sample(-32768, -32768, -32768, 32767, 32767, 32767));
		dir.push_back(make_sample(-32768, 0, 0, 0, -32768, 0));
		dir.push_back(make_sample(32767, -32768, 32767, -32768, 32767, -32768));
		dir.push_back(make_sample(1, 0, 0, 0, 1, 0));
		dir.push_back(make_sample(0, 0, -16384, 10000, 0, 0));
		dir.push_back(make_sample(16384, 0, 0, 0, 5000, 5000));
		dir.push_back(make_sample(0, 0, 16384, 10000, 175, 0));
		foreach (dir[i]) send_sample(dir[i]);
		drain();

		// Facing along the device z axis: dot products vanish for level samples.
		write_facing(tcch_pkg::CFG_FACING_X, 16'sd0);
		write_facing(tcch_pkg::CFG_FACING_Z, 16'sd1);
		foreach (dir[i]) send_sample(dir[i]);
		random_phase(60);
		drain();

		// Zero facing vector, then extreme and random settings with stalls.
		write_facing(tcch_pkg::CFG_FACING_Z, 16'sd0);
		random_phase(40);
		drain();
		stall_mode = 1;
		write_facing(tcch_pkg::CFG_FACING_X, 16'h7fff);
		write_facing(tcch_pkg::CFG_FACING_Y, 16'h8000);
		write_facing(tcch_pkg::CFG_FACING_Z, 16'h7fff);
		random_phase(300);
		drain();
		stall_mode = 2;
		write_facing(tcch_pkg::CFG_FACING_X, 16'h8000);
		write_facing(tcch_pkg::CFG_FACING_Y, 16'h7fff);
		write_facing(tcch_pkg::CFG_FACING_Z, 16'h8000);
		random_phase(300);
		drain();
		for (int ph = 0; ph < 3; ph++) begin
			stall_mode = ph;
			write_facing(tcch_pkg::CFG_FACING_X, rand_field());
			write_facing(tcch_pkg::CFG_FACING_Y, rand_field());
			write_facing(tcch_pkg::CFG_FACING_Z, rand_field());
			random_phase(200);
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("tilt_compensated_compass_heading test passed");
		end else begin
			$display("tilt_compensated_compass_heading test failed");
		end
		$finish;
	end

endmodule
